FILE: rtl/cleq_pkg.sv
// ----------------------------------------------------------------------------
// cleq_pkg
// Shared types, widths and codes of the circular linked queue engine.
// ----------------------------------------------------------------------------
package cleq_pkg;

  localparam int ID_W          = 6;
  localparam int CNT_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int MAX_ITEMS_DEF = 64;

  // operation codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] STS_PRESENT = 2'd3;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] item_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [ID_W-1:0]     head_item;
    logic [CNT_W-1:0]    count;
  } out_item_t;

endpackage

FILE: rtl/cleq_ram.sv
// ----------------------------------------------------------------------------
// cleq_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module cleq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/circular_linked_queue_engine.sv
// ----------------------------------------------------------------------------
// circular_linked_queue_engine
// Result: an accepted item moves the sequencer to ST_LINK, and its result is
//   registered into the output or spare result register when that cycle ends.
// Occupancy: no item is taken in ST_LINK, as link RAM reads are registered:
//   links are read in the accept cycle, neighbours written in the next.
// Stalls: a spare result register lets one more item through while a result
//   waits; outside ST_LINK, input stalls only with both result registers full.
// Reset: synchronous active-low rst_n empties the queue and clears membership;
//   link RAMs are not cleared (only members' links are ever read).
// ----------------------------------------------------------------------------
module circular_linked_queue_engine #(
  parameter int MAX_ITEMS = cleq_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cleq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cleq_pkg::out_item_t out_data
);

  localparam int IdW   = cleq_pkg::ID_W;
  localparam int CntW  = cleq_pkg::CNT_W;
  localparam int StsW  = cleq_pkg::STATUS_W;
  localparam int IdxW  = $clog2(MAX_ITEMS);
  // only identifiers that fit the item_id field can ever be members
  localparam int FlagN = (MAX_ITEMS < 2**IdW) ? MAX_ITEMS : 2**IdW;
  localparam int FlagW = $clog2(FlagN);

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;  // waiting for an item, reads issued on accept
  localparam logic ST_LINK = 1'b1;  // read data back, neighbour links written

  logic                state_r, state_nxt;
  logic [FlagN-1:0]    flag_r, flag_nxt;
  logic [IdxW-1:0]     head_r, head_nxt;
  logic                present_r, present_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  // item held from the accept cycle into the link cycle
  logic                do_app_r, do_rem_r;
  logic [IdxW-1:0]     id_r;
  logic [StsW-1:0]     status_r;

  logic                out_valid_r, out_valid_nxt;
  cleq_pkg::out_item_t out_data_r, out_data_nxt;

  // spare result register, behind out_data_r in order
  logic                pend_valid_r, pend_valid_nxt;
  cleq_pkg::out_item_t pend_data_r, pend_data_nxt;
  cleq_pkg::out_item_t link_res;

  // accept-cycle decode
  logic                accept;
  logic                in_id_ok;
  logic                in_member;
  logic [IdxW-1:0]     in_idx;
  logic                app_ok, rem_ok;
  logic [StsW-1:0]     in_status;

  // link RAM ports
  logic                next_we, prev_we;
  logic [IdxW-1:0]     next_wa, prev_wa, next_ra, prev_ra;
  logic [IdxW-1:0]     next_wd, prev_wd, next_rd, prev_rd;

  // --------------------------------------------------------------------------
  // Handshake: an item may enter in ST_IDLE while the spare register is free.
  // --------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE) && !pend_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Decode: membership flag stands in for a list walk.
  // --------------------------------------------------------------------------
  assign in_id_ok  = 32'(in_data.item_id) < MAX_ITEMS;
  assign in_member = in_id_ok && flag_r[in_data.item_id[FlagW-1:0]];
  assign in_idx    = IdxW'(in_data.item_id);

  always_comb begin
    app_ok    = 1'b0;
    rem_ok    = 1'b0;
    in_status = cleq_pkg::STS_OK;
    if (in_data.cmd == cleq_pkg::CMD_APPEND) begin
      if (in_member || !in_id_ok) begin
        in_status = cleq_pkg::STS_PRESENT;
      end else begin
        app_ok = 1'b1;
      end
    end else begin
      if (!present_r) begin
        in_status = cleq_pkg::STS_EMPTY;
      end else if (!in_member) begin
        in_status = cleq_pkg::STS_MISSING;
      end else begin
        rem_ok = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Link RAM access.
  // Append, accept cycle: read tail = prev[head], write prev[head] = id and
  //   next[id] = head (RAM is read-first, so the old tail comes back).
  // Append, link cycle: prev[id] = tail, next[tail] = id.
  // Append to empty queue: item links to itself.
  // Remove, accept cycle: read succ = next[id], pred = prev[id].
  // Remove, link cycle: next[pred] = succ, prev[succ] = pred.
  // --------------------------------------------------------------------------
  always_comb begin
    next_we = 1'b0;
    next_wa = in_idx;
    next_wd = head_r;
    next_ra = in_idx;
    prev_we = 1'b0;
    prev_wa = head_r;
    prev_wd = in_idx;
    prev_ra = in_idx;
    if (accept && app_ok) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (present_r) begin
        prev_ra = head_r;
      end else begin
        next_wd = in_idx;
        prev_wa = in_idx;
      end
    end
    if (state_r == ST_LINK) begin
      if (do_app_r && present_r) begin
        prev_we = 1'b1;
        prev_wa = id_r;
        prev_wd = prev_rd;
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = id_r;
      end
      if (do_rem_r) begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wa = next_rd;
        prev_wd = prev_rd;
      end
    end
  end

  cleq_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_ITEMS)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_addr (next_ra),
    .rd_data (next_rd)
  );

  cleq_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_ITEMS)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_we),
    .wr_addr (prev_wa),
    .wr_data (prev_wd),
    .rd_addr (prev_ra),
    .rd_data (prev_rd)
  );

  // --------------------------------------------------------------------------
  // Queue state update in the link cycle, and the result it produces.
  // --------------------------------------------------------------------------
  always_comb begin
    flag_nxt    = flag_r;
    head_nxt    = head_r;
    present_nxt = present_r;
    count_nxt   = count_r;
    if (state_r == ST_LINK) begin
      if (do_app_r) begin
        flag_nxt[id_r[FlagW-1:0]] = 1'b1;
        count_nxt = count_r + CntW'(1);
        if (!present_r) begin
          head_nxt    = id_r;
          present_nxt = 1'b1;
        end
      end
      if (do_rem_r) begin
        flag_nxt[id_r[FlagW-1:0]] = 1'b0;
        count_nxt = count_r - CntW'(1);
        if (head_r == id_r) begin
          // head leaves: successor takes over, or the queue empties
          if (next_rd == id_r) begin
            present_nxt = 1'b0;
            head_nxt    = '0;
          end else begin
            head_nxt = next_rd;
          end
        end
      end
    end
  end

  // result of the item in the link cycle; goes to the output register if that
  // is free by the edge, else into the spare register behind it
  always_comb begin
    link_res.status     = status_r;
    link_res.head_valid = present_nxt;
    link_res.head_item  = present_nxt ? IdW'(head_nxt) : '0;
    link_res.count      = count_nxt;
    out_data_nxt        = out_data_r;
    out_valid_nxt       = out_valid_r;
    pend_data_nxt       = pend_data_r;
    pend_valid_nxt      = pend_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt  = pend_valid_r;
      out_data_nxt   = pend_data_r;
      pend_valid_nxt = 1'b0;
    end
    if (state_r == ST_LINK) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = link_res;
      end else begin
        pend_valid_nxt = 1'b1;
        pend_data_nxt  = link_res;
      end
    end
  end

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_LINK : ST_IDLE;
      ST_LINK: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flag_r       <= '0;
      head_r       <= '0;
      present_r    <= 1'b0;
      count_r      <= '0;
      do_app_r     <= 1'b0;
      do_rem_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_r       <= flag_nxt;
      head_r       <= head_nxt;
      present_r    <= present_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (accept) begin
        do_app_r <= app_ok;
        do_rem_r <= rem_ok;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r     <= in_idx;
      status_r <= in_status;
    end
    out_data_r  <= out_data_nxt;
    pend_data_r <= pend_data_nxt;
  end

`ifndef ASSERT_OFF
  a_present_count : assert property (@(posedge clk) disable iff (!rst_n)
    present_r == (count_r != '0))
    else $error("head flag disagrees with count");

  a_members_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flag_r) == 32'(count_r))
    else $error("membership flags disagree with count");

  a_result_timing : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LINK) ##1 out_valid_r)
    else $error("result not produced two cycles after accept");

  a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK && do_rem_r) |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("successful remove did not shrink the queue");
`endif

endmodule
